### rtl/dqph_pkg.sv
package dqph_pkg;

	localparam int HEADER_BYTES = 12;
	localparam int RES_DEPTH = 4;

	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_MULT = 32'h0100_0193;
	localparam logic [7:0] MAX_NAME_LEN_RST = 8'hFF;
	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [2:0] FIXED_BYTES = 3'd4;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LEN,
		PH_LABEL,
		PH_FIXED,
		PH_ANSWER,
		PH_TAIL,
		PH_SINK
	} phase_t;

	typedef enum logic [1:0] {
		KIND_CHAR,
		KIND_ANSWER,
		KIND_SUMMARY
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_TOO_LONG,
		ST_EMPTY,
		ST_TRUNC
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		kind_t       out_kind;
		logic [7:0]  out_byte;
		logic        is_response;
		logic [31:0] qname_hash;
		logic [31:0] id_qname_hash;
		logic [9:0]  answer_length;
		status_t     status;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic [7:0] max_name_len;
	} cfg_item_t;

	// Up to two results written into the result queue in one cycle, e0 first.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  e0;
		out_item_t  e1;
	} res_push_t;

	function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * FNV_MULT;
	endfunction

endpackage

### rtl/dqph_stream_if.sv
interface dqph_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/dqph_parser.sv
module dqph_parser import dqph_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  in_item_t   in_item,
	output logic       in_ready,
	input  logic [7:0] max_name_len,
	input  logic       room,
	output res_push_t  push
);

	localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);
	localparam logic [POS_W-1:0] POS_HDR = POS_W'(HEADER_BYTES);

	in_item_t   item_s1;
	logic       valid_s1;
	logic       step;

	logic [POS_W-1:0] pos_q, pos_n;
	logic             resp_q, resp_n;
	phase_t           phase_q, phase_n;
	logic [7:0]       lbl_q, lbl_n;
	logic [8:0]       name_len_q, name_len_n;
	logic [2:0]       fixed_q, fixed_n;
	logic [31:0]      qhash_q, qhash_n;
	logic [31:0]      chash_q, chash_n;
	status_t          err_q, err_n;
	logic [9:0]       ans_q, ans_n;

	logic [7:0]  b;
	logic [9:0]  len_sum;
	logic        first_v;
	kind_t       first_kind;
	logic [7:0]  first_byte;
	status_t     sum_status;
	out_item_t   first_res;
	out_item_t   sum_res;

	assign step = valid_s1 && room;
	assign in_ready = !valid_s1 || step;
	assign b = item_s1.data_byte;
	assign len_sum = {1'b0, name_len_q} + {2'b00, b} + 10'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		pos_n = pos_q;
		resp_n = resp_q;
		phase_n = phase_q;
		lbl_n = lbl_q;
		name_len_n = name_len_q;
		fixed_n = fixed_q;
		qhash_n = qhash_q;
		chash_n = chash_q;
		err_n = err_q;
		ans_n = ans_q;
		first_v = 1'b0;
		first_kind = KIND_CHAR;
		first_byte = 8'd0;
		sum_status = ST_OK;

		if (pos_q >= POS_MAX) begin
			// Bytes past the size limit are dropped; they mark an error-free message truncated.
			if (err_q == ST_OK) begin
				err_n = ST_TRUNC;
			end
		end else begin
			pos_n = pos_q + 1'b1;
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == '0 || pos_q == POS_W'(1)) begin
						chash_n = fnv_step(chash_q, b);
					end
					if (pos_q == POS_W'(2)) begin
						resp_n = b[7];
					end
					if (pos_n >= POS_HDR) begin
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					if (len_sum > {2'b00, max_name_len}) begin
						err_n = ST_TOO_LONG;
						phase_n = PH_SINK;
					end else if (b == 8'd0) begin
						if (!resp_q && name_len_q == 9'd0) begin
							err_n = ST_EMPTY;
							phase_n = PH_SINK;
						end else if (resp_q) begin
							fixed_n = FIXED_BYTES;
							phase_n = PH_FIXED;
						end else begin
							phase_n = PH_TAIL;
						end
					end else begin
						qhash_n = fnv_step(qhash_q, b);
						chash_n = fnv_step(chash_q, b);
						if (!resp_q && name_len_q != 9'd0) begin
							first_v = 1'b1;
							first_kind = KIND_CHAR;
							first_byte = DOT_CHAR;
						end
						name_len_n = len_sum[8:0];
						lbl_n = b;
						phase_n = PH_LABEL;
					end
				end
				PH_LABEL: begin
					qhash_n = fnv_step(qhash_q, b);
					chash_n = fnv_step(chash_q, b);
					if (!resp_q) begin
						first_v = 1'b1;
						first_kind = KIND_CHAR;
						first_byte = b;
					end
					lbl_n = lbl_q - 8'd1;
					if (lbl_n == 8'd0) begin
						phase_n = PH_LEN;
					end
				end
				PH_FIXED: begin
					fixed_n = fixed_q - 3'd1;
					if (fixed_n == 3'd0) begin
						phase_n = PH_ANSWER;
					end
				end
				PH_ANSWER: begin
					first_v = 1'b1;
					first_kind = KIND_ANSWER;
					first_byte = b;
					ans_n = ans_q + 10'd1;
				end
				PH_TAIL, PH_SINK: begin
				end
				default: begin
				end
			endcase
		end

		sum_status = err_n;
		if (err_n == ST_OK && (phase_n == PH_HEADER || phase_n == PH_LEN ||
				phase_n == PH_LABEL || phase_n == PH_FIXED)) begin
			sum_status = ST_TRUNC;
		end

		first_res = '{out_kind: first_kind, out_byte: first_byte, is_response: resp_n,
			qname_hash: 32'd0, id_qname_hash: 32'd0, answer_length: 10'd0,
			status: ST_OK, last_result: 1'b0};
		sum_res = '{out_kind: KIND_SUMMARY, out_byte: 8'd0, is_response: resp_n,
			qname_hash: qhash_n, id_qname_hash: chash_n, answer_length: ans_n,
			status: sum_status, last_result: 1'b1};

		push.count = 2'd0;
		push.e0 = sum_res;
		push.e1 = sum_res;
		if (step) begin
			if (first_v) begin
				push.e0 = first_res;
				push.count = item_s1.last_byte ? 2'd2 : 2'd1;
			end else begin
				push.count = item_s1.last_byte ? 2'd1 : 2'd0;
			end
		end

		// The last byte ends the message: all parse state returns to its reset value.
		if (item_s1.last_byte) begin
			pos_n = '0;
			resp_n = 1'b0;
			phase_n = PH_HEADER;
			lbl_n = 8'd0;
			name_len_n = 9'd0;
			fixed_n = 3'd0;
			qhash_n = FNV_BASIS;
			chash_n = FNV_BASIS;
			err_n = ST_OK;
			ans_n = 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			resp_q <= 1'b0;
			phase_q <= PH_HEADER;
			lbl_q <= 8'd0;
			name_len_q <= 9'd0;
			fixed_q <= 3'd0;
			qhash_q <= FNV_BASIS;
			chash_q <= FNV_BASIS;
			err_q <= ST_OK;
			ans_q <= 10'd0;
		end else if (step) begin
			pos_q <= pos_n;
			resp_q <= resp_n;
			phase_q <= phase_n;
			lbl_q <= lbl_n;
			name_len_q <= name_len_n;
			fixed_q <= fixed_n;
			qhash_q <= qhash_n;
			chash_q <= chash_n;
			err_q <= err_n;
			ans_q <= ans_n;
		end
	end

	a_sink_has_error: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SINK |-> err_q != ST_OK)
		else $error("parser idles in sink phase without an error code");

	a_pos_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position ran past the message size limit");

	a_label_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LABEL |-> lbl_q != 8'd0)
		else $error("label phase entered with no label bytes left");

	a_fixed_response: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIXED |-> (fixed_q != 3'd0 && resp_q))
		else $error("fixed field skip outside a response or with zero count");

endmodule

### rtl/dqph_res_fifo.sv
module dqph_res_fifo import dqph_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_push_t push,
	output logic      room,
	dqph_stream_if.source res
);

	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);
	localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(RES_DEPTH - 2);

	out_item_t        mem_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic [PTR_W-1:0] wr_ptr_p1;

	// Room for two results, so a byte that ends the message never overflows.
	assign room = cnt_q <= ROOM_LIMIT;
	assign res.valid = cnt_q != '0;
	assign res.payload = mem_q[rd_ptr_q];
	assign pop = res.valid && res.ready;
	assign wr_ptr_p1 = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.e0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(RES_DEPTH))
		else $error("result queue holds more than its depth");

	a_push_with_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("result written while the queue lacks room");

	a_push_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two results from one byte");

endmodule

### rtl/dns_question_parser_hasher.sv
// Channel | Dir | Payload                                          | Handshake
// msg     | in  | data_byte[7:0], last_byte                        | valid/ready
// res     | out | out_kind, out_byte, is_response, qname_hash,     | valid/ready
//         |     | id_qname_hash, answer_length, status, last_result |
// cfg     | in  | max_name_len[7:0]                                | valid/ready
//
// One message byte is taken per cycle; it is registered before its results are queued.
// A byte that yields a character or answer byte and also ends the message puts two
// results into the four-entry queue, which drains one result per cycle when res is ready.
// Input stalls only when that queue has fewer than two free entries.
// arst_n clears the parse state and sets max_name_len to 255; cfg is always ready.
module dns_question_parser_hasher import dqph_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 512
) (
	input logic clk,
	input logic arst_n,
	dqph_stream_if.sink   msg,
	dqph_stream_if.source res,
	dqph_stream_if.sink   cfg
);

	logic [7:0] max_name_len_q;
	logic       room;
	logic       in_ready;
	res_push_t  push;
	cfg_item_t  cfg_item;

	assign cfg.ready = 1'b1;
	assign cfg_item = cfg.payload;
	assign msg.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= MAX_NAME_LEN_RST;
		end else if (cfg.valid) begin
			max_name_len_q <= cfg_item.max_name_len;
		end
	end

	dqph_parser #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(msg.valid),
		.in_item(msg.payload),
		.in_ready(in_ready),
		.max_name_len(max_name_len_q),
		.room(room),
		.push(push)
	);

	dqph_res_fifo u_res_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.res(res)
	);

endmodule

### tb/dns_question_parser_hasher_tb.sv
`timescale 1ns / 100ps

module dns_question_parser_hasher_tb;
	import dqph_pkg::*;

	localparam int MAX_MESSAGE_BYTES = 512;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_BYTES = 360;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_LIMIT = 40;

	// One directed message. The first label length sits in the top byte of labels and
	// the list stops at the first zero. A nonzero cut ends the message on that byte.
	typedef struct packed {
		logic [7:0]  limit;
		logic        resp;
		logic [15:0] id;
		logic [31:0] labels;
		logic [15:0] extra;
		logic [15:0] cut;
		status_t     st;
	} directed_row_t;

	localparam int NUM_ROWS = 22;
	localparam directed_row_t DIRECTED [NUM_ROWS] = '{
		'{8'd255, 1'b0, 16'h0000, 32'h0307_0000, 16'd0,   16'd0,  ST_OK},
		'{8'd255, 1'b0, 16'hFFFF, 32'h0100_0000, 16'd3,   16'd0,  ST_OK},
		'{8'd255, 1'b1, 16'h1234, 32'h0302_0000, 16'd5,   16'd0,  ST_OK},
		'{8'd255, 1'b1, 16'hA5A5, 32'h0000_0000, 16'd2,   16'd0,  ST_OK},
		'{8'd255, 1'b0, 16'h5A5A, 32'h0000_0000, 16'd2,   16'd0,  ST_EMPTY},
		'{8'd255, 1'b1, 16'h0001, 32'h0000_0000, 16'd0,   16'd15, ST_TRUNC},
		'{8'd255, 1'b0, 16'h0100, 32'h0100_0000, 16'd0,   16'd1,  ST_TRUNC},
		'{8'd255, 1'b1, 16'h0100, 32'h0100_0000, 16'd0,   16'd12, ST_TRUNC},
		'{8'd255, 1'b0, 16'h0200, 32'h0500_0000, 16'd0,   16'd15, ST_TRUNC},
		'{8'd255, 1'b0, 16'h0300, 32'h0100_0000, 16'd0,   16'd14, ST_TRUNC},
		'{8'd255, 1'b0, 16'h7F80, 32'h4000_0000, 16'd1,   16'd0,  ST_OK},
		'{8'd255, 1'b0, 16'h0000, 32'h3F3F_3F3D, 16'd0,   16'd0,  ST_OK},
		'{8'd255, 1'b1, 16'h0000, 32'hFF00_0000, 16'd0,   16'd14, ST_TOO_LONG},
		'{8'd10,  1'b0, 16'h4321, 32'h0405_0000, 16'd0,   16'd18, ST_TOO_LONG},
		'{8'd10,  1'b1, 16'h8765, 32'h0403_0000, 16'd2,   16'd0,  ST_OK},
		'{8'd0,   1'b1, 16'hFFFF, 32'h0000_0000, 16'd0,   16'd0,  ST_TOO_LONG},
		'{8'd0,   1'b0, 16'h0F0F, 32'h0100_0000, 16'd0,   16'd0,  ST_TOO_LONG},
		'{8'd1,   1'b1, 16'hF0F0, 32'h0000_0000, 16'd1,   16'd0,  ST_OK},
		'{8'd1,   1'b0, 16'h3C3C, 32'h0000_0000, 16'd0,   16'd0,  ST_EMPTY},
		'{8'd255, 1'b1, 16'hC3C3, 32'h0100_0000, 16'd500, 16'd0,  ST_TRUNC},
		'{8'd255, 1'b0, 16'h6996, 32'h0000_0000, 16'd500, 16'd0,  ST_EMPTY},
		'{8'd255, 1'b1, 16'h9669, 32'h0200_0000, 16'd0,   16'd0,  ST_OK}
	};

	logic clk = 1'b0;
	logic arst_n;

	dqph_stream_if #(.payload_t(in_item_t))  msg();
	dqph_stream_if #(.payload_t(out_item_t)) res();
	dqph_stream_if #(.payload_t(cfg_item_t)) cfg();

	dns_question_parser_hasher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.res(res),
		.cfg(cfg)
	);

	always #6 clk = ~clk;

	// Parser state kept by the testbench.
	logic [7:0]  name_limit;
	int          byte_pos;
	logic        resp_flag;
	phase_t      phase;
	int          label_left;
	int          name_len;
	int          fixed_left;
	logic [31:0] name_hash;
	logic [31:0] id_name_hash;
	status_t     err;
	logic [9:0]  answer_count;

	out_item_t   results_due[$];
	logic [7:0]  frame[$];
	status_t     last_status;
	bit          steady = 1'b0;
	int          fail_count = 0;
	int          bytes_accepted = 0;
	int          cycle_count = 0;

	function automatic logic [31:0] fnv1a(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] mixed;
		mixed = h ^ {24'd0, b};
		return mixed * FNV_MULT;
	endfunction

	function automatic out_item_t make_result(input kind_t k, input logic [7:0] ch,
			input logic [31:0] qh, input logic [31:0] chh, input logic [9:0] alen,
			input status_t st, input logic fin);
		out_item_t r;
		r.out_kind = k;
		r.out_byte = ch;
		r.is_response = resp_flag;
		r.qname_hash = qh;
		r.id_qname_hash = chh;
		r.answer_length = alen;
		r.status = st;
		r.last_result = fin;
		return r;
	endfunction

	task automatic clear_parse_state();
		byte_pos = 0;
		resp_flag = 1'b0;
		phase = PH_HEADER;
		label_left = 0;
		name_len = 0;
		fixed_left = 0;
		name_hash = FNV_BASIS;
		id_name_hash = FNV_BASIS;
		err = ST_OK;
		answer_count = '0;
	endtask

	// Works out the results that one accepted message byte causes.
	task automatic parse_message_byte(input logic [7:0] b, input logic fin);
		int p;
		status_t st;
		if (byte_pos >= MAX_MESSAGE_BYTES) begin
			if (err == ST_OK)
				err = ST_TRUNC;
		end else begin
			p = byte_pos;
			byte_pos = p + 1;
			case (phase)
				PH_HEADER: begin
					if (p == 0 || p == 1)
						id_name_hash = fnv1a(id_name_hash, b);
					else if (p == 2)
						resp_flag = b[7];
					if (byte_pos >= HEADER_BYTES)
						phase = PH_LEN;
				end
				PH_LEN: begin
					if (name_len + int'(b) + 1 > int'(name_limit)) begin
						err = ST_TOO_LONG;
						phase = PH_SINK;
					end else if (b == 8'd0) begin
						if (!resp_flag && name_len == 0) begin
							err = ST_EMPTY;
							phase = PH_SINK;
						end else if (resp_flag) begin
							fixed_left = FIXED_BYTES;
							phase = PH_FIXED;
						end else begin
							phase = PH_TAIL;
						end
					end else begin
						name_hash = fnv1a(name_hash, b);
						id_name_hash = fnv1a(id_name_hash, b);
						if (!resp_flag && name_len > 0)
							results_due.push_back(make_result(KIND_CHAR, DOT_CHAR,
								'0, '0, '0, ST_OK, 1'b0));
						name_len = name_len + int'(b) + 1;
						label_left = int'(b);
						phase = PH_LABEL;
					end
				end
				PH_LABEL: begin
					name_hash = fnv1a(name_hash, b);
					id_name_hash = fnv1a(id_name_hash, b);
					if (!resp_flag)
						results_due.push_back(make_result(KIND_CHAR, b, '0, '0, '0,
							ST_OK, 1'b0));
					label_left = label_left - 1;
					if (label_left == 0)
						phase = PH_LEN;
				end
				PH_FIXED: begin
					fixed_left = fixed_left - 1;
					if (fixed_left == 0)
						phase = PH_ANSWER;
				end
				PH_ANSWER: begin
					results_due.push_back(make_result(KIND_ANSWER, b, '0, '0, '0,
						ST_OK, 1'b0));
					answer_count = answer_count + 10'd1;
				end
				default: begin
				end
			endcase
		end
		if (fin) begin
			st = err;
			if (st == ST_OK && (phase == PH_HEADER || phase == PH_LEN ||
					phase == PH_LABEL || phase == PH_FIXED))
				st = ST_TRUNC;
			results_due.push_back(make_result(KIND_SUMMARY, 8'd0, name_hash, id_name_hash,
				answer_count, st, 1'b1));
			clear_parse_state();
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (fail_count < PRINT_LIMIT)
			$display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		fail_count++;
	endtask

	task automatic compare_result(input out_item_t got, input out_item_t want);
		if (got.out_kind !== want.out_kind)
			flag_mismatch("out_kind", 32'(got.out_kind), 32'(want.out_kind));
		if (got.out_byte !== want.out_byte)
			flag_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
		if (got.is_response !== want.is_response)
			flag_mismatch("is_response", 32'(got.is_response), 32'(want.is_response));
		if (got.qname_hash !== want.qname_hash)
			flag_mismatch("qname_hash", got.qname_hash, want.qname_hash);
		if (got.id_qname_hash !== want.id_qname_hash)
			flag_mismatch("id_qname_hash", got.id_qname_hash, want.id_qname_hash);
		if (got.answer_length !== want.answer_length)
			flag_mismatch("answer_length", 32'(got.answer_length), 32'(want.answer_length));
		if (got.status !== want.status)
			flag_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.last_result !== want.last_result)
			flag_mismatch("last_result", 32'(got.last_result), 32'(want.last_result));
	endtask

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (results_due.size() == 0)
				flag_mismatch("result with nothing due, kind", 32'(res.payload.out_kind), '0);
			else
				compare_result(res.payload, results_due.pop_front());
			if (res.payload.out_kind == KIND_SUMMARY)
				last_status = res.payload.status;
		end
		res.ready <= steady || ($urandom_range(99) >= 18);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dns_question_parser_hasher_tb: FAIL");
			$finish;
		end
	end

	// Offers one byte, idling at random first, and predicts once it is taken.
	task automatic push_byte(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(99) < 18) begin
			msg.valid <= 1'b0;
			@(posedge clk);
		end
		msg.valid <= 1'b1;
		msg.payload <= {b, fin};
		@(posedge clk);
		while (!msg.ready)
			@(posedge clk);
		bytes_accepted++;
		parse_message_byte(b, fin);
	endtask

	// Holds the sender off until every due result is in and the pipeline has emptied.
	task automatic wait_until_idle();
		msg.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_name_limit(input logic [7:0] v);
		wait_until_idle();
		cfg.valid <= 1'b1;
		cfg.payload <= v;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		name_limit = v;
	endtask

	task automatic start_frame(input logic resp, input logic [15:0] id);
		frame.delete();
		frame.push_back(id[15:8]);
		frame.push_back(id[7:0]);
		frame.push_back({resp, 7'($urandom)});
		repeat (HEADER_BYTES - 3) frame.push_back(8'($urandom));
	endtask

	task automatic add_label(input logic [7:0] len);
		frame.push_back(len);
		repeat (int'(len)) frame.push_back(8'($urandom));
	endtask

	task automatic finish_frame(input logic resp, input int extra);
		frame.push_back(8'd0);
		if (resp)
			repeat (FIXED_BYTES) frame.push_back(8'($urandom));
		repeat (extra) frame.push_back(8'($urandom));
	endtask

	task automatic transmit(input int cut);
		int n;
		n = (cut > 0 && cut < frame.size()) ? cut : frame.size();
		for (int i = 0; i < n; i++)
			push_byte(frame[i], i == n - 1);
	endtask

	initial begin
		directed_row_t row;
		logic [7:0] len;
		logic resp;
		int msg_count;
		int start_bytes;
		int nlab;
		int r;
		arst_n <= 1'b0;
		msg.valid <= 1'b0;
		msg.payload <= '0;
		cfg.valid <= 1'b0;
		cfg.payload <= '0;
		name_limit = MAX_NAME_LEN_RST;
		clear_parse_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.limit != name_limit)
				write_name_limit(row.limit);
			start_frame(row.resp, row.id);
			for (int k = 3; k >= 0; k--) begin
				len = row.labels[k*8 +: 8];
				if (len == 8'd0)
					break;
				add_label(len);
			end
			finish_frame(row.resp, int'(row.extra));
			transmit(int'(row.cut));
			wait_until_idle();
			if (last_status !== row.st)
				flag_mismatch("directed message status", 32'(last_status), 32'(row.st));
		end

		msg_count = 0;
		start_bytes = bytes_accepted;
		while (bytes_accepted - start_bytes < RANDOM_BYTES) begin
			msg_count++;
			steady = (msg_count >= 2 && msg_count < 5);
			if (msg_count % 3 == 0) begin
				r = $urandom_range(9);
				case (r)
					0: write_name_limit(8'd0);
					1: write_name_limit(8'd1);
					2, 3: write_name_limit(8'($urandom_range(8, 40)));
					default: write_name_limit(8'd255);
				endcase
			end
			if ($urandom_range(99) < 8) begin
				// A stream of arbitrary bytes, cut anywhere.
				frame.delete();
				repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
				transmit(0);
			end else begin
				resp = 1'($urandom);
				start_frame(resp, 16'($urandom));
				nlab = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 4);
				for (int k = 0; k < nlab; k++) begin
					if ($urandom_range(99) < 5)
						add_label(8'($urandom_range(64, 255)));
					else
						add_label(8'($urandom_range(1, 15)));
				end
				finish_frame(resp, $urandom_range(0, 24));
				transmit(($urandom_range(99) < 10) ? $urandom_range(1, frame.size()) : 0);
			end
		end
		steady = 1'b0;

		wait_until_idle();
		if (fail_count == 0)
			$display("dns_question_parser_hasher_tb: PASS");
		else
			$display("dns_question_parser_hasher_tb: FAIL");
		$finish;
	end

endmodule
